// File: hw/rtl/sspt_pkg.sv
package sspt_pkg;

	localparam int TICK_WIDTH_DEF   = 32;
	localparam int SOURCE_WIDTH_DEF = 8;

	localparam int SRC_W    = 8;
	localparam int TICK_W   = 32;
	localparam int ZONE_W   = 16;
	localparam int SPEED_W  = 16;
	localparam int POS_W    = 32;
	localparam int COUNT_W  = 32;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ID    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_LEVEL  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZONE_LENGTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 2'd3;

	localparam logic [ZONE_W-1:0] ZONE_RESET  = 16'd1;
	localparam logic [SPEED_W-1:0] SPEED_SAT  = '1;

	typedef struct packed {
		logic               done;
		logic [SPEED_W-1:0] quotient;
	} div_res_t;

endpackage

// File: hw/rtl/sspt_div.sv
module sspt_div #(
	parameter int TICK_WIDTH = sspt_pkg::TICK_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sspt_pkg::ZONE_W-1:0]   dividend,
	input  logic [TICK_WIDTH-1:0]         divisor,
	output sspt_pkg::div_res_t            res
);

	localparam int QW     = sspt_pkg::SPEED_W;
	localparam int ITER_W = $clog2(QW);

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] cnt_q;
	logic [TICK_WIDTH:0] rem_q;
	logic [TICK_WIDTH-1:0] dvs_q;
	logic [QW-1:0]     quo_q;

	logic [TICK_WIDTH:0] shifted;
	logic [TICK_WIDTH:0] dvs_ext;
	logic                fits;

	// one restoring step per cycle
	assign shifted = {rem_q[TICK_WIDTH-1:0], quo_q[QW-1]};
	assign dvs_ext = {1'b0, dvs_q};
	assign fits    = (shifted >= dvs_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ITER_W'(QW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= QW'(dividend);
		end else if (busy_q) begin
			rem_q <= fits ? (shifted - dvs_ext) : shifted;
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

	assign res.done     = done_q;
	assign res.quotient = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start)
		else $error("divider restarted while busy");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < dvs_ext))
		else $error("divider remainder not below divisor");

	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("divider done without a finished run");

endmodule

// File: hw/rtl/strobe_speed_position_tracker.sv
// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  s_tdata: event_source, event_level, event_tick
// m        out  m_tvalid/m_tready  m_tdata: position, speed, count; m_tuser: flags
// cfg      in   cfg_we             cfg_addr, cfg_data
// a strobe goes through 16 divider steps, the quotient into speed, one multiply, one add
// and the output register before m_tvalid rises
// a zero-interval strobe skips the divider; a non-strobe event goes straight to ST_DONE
// s_tready is high only while the sequencer is idle, so the next accept comes at the
// earliest while m_tvalid is high; a held result stalls the next one in ST_DONE, and s_tready
// with it; reset clears state, counters and the config registers to their defaults
module strobe_speed_position_tracker #(
	parameter int TICK_WIDTH   = sspt_pkg::TICK_WIDTH_DEF,
	parameter int SOURCE_WIDTH = sspt_pkg::SOURCE_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [47:0]                     s_tdata,  // event_source, event_level, event_tick
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [79:0]                     m_tdata,  // position_now, speed_now, strobes_seen
	output logic [1:0]                      m_tuser,  // strobe_hit, zero_interval
	input  logic                            cfg_we,
	input  logic [sspt_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [sspt_pkg::CFG_W-1:0]      cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_ADD,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [sspt_pkg::SRC_W-1:0]   src_id_q;
	logic                         level_q;
	logic [sspt_pkg::ZONE_W-1:0]  zone_q;
	logic [sspt_pkg::POS_W-1:0]   offset_q;

	logic [TICK_WIDTH-1:0]        prev_tick_q;
	logic [sspt_pkg::COUNT_W-1:0] count_q;
	logic [sspt_pkg::SPEED_W-1:0] speed_q;
	logic [sspt_pkg::POS_W-1:0]   pos_q;
	logic [sspt_pkg::POS_W-1:0]   prod_q;
	logic                         hit_q;
	logic                         zero_q;

	logic [sspt_pkg::SRC_W-1:0]   ev_src;
	logic                         ev_level;
	logic [TICK_WIDTH-1:0]        ev_tick;
	logic [TICK_WIDTH-1:0]        diff;
	logic                         is_hit;
	logic                         accept;
	logic                         div_start;
	logic                         out_free;
	logic [sspt_pkg::COUNT_W+sspt_pkg::ZONE_W-1:0] prod_full;
	sspt_pkg::div_res_t           div_res;

	assign ev_src   = s_tdata[7:0];
	assign ev_level = s_tdata[8];
	assign ev_tick  = TICK_WIDTH'(s_tdata[40:9]);

	assign is_hit = (SOURCE_WIDTH'(ev_src) == SOURCE_WIDTH'(src_id_q)) &&
		(ev_level == level_q);
	assign diff      = ev_tick - prev_tick_q;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign div_start = accept && is_hit && (diff != '0);
	assign out_free  = !m_tvalid || m_tready;
	assign prod_full = count_q * zone_q;

	sspt_div #(
		.TICK_WIDTH(TICK_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (zone_q),
		.divisor  (diff),
		.res      (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_id_q <= '0;
			level_q  <= 1'b1;
			zone_q   <= sspt_pkg::ZONE_RESET;
			offset_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				sspt_pkg::REG_SOURCE_ID:    src_id_q <= cfg_data[sspt_pkg::SRC_W-1:0];
				sspt_pkg::REG_MATCH_LEVEL:  level_q  <= cfg_data[0];
				sspt_pkg::REG_ZONE_LENGTH:  zone_q   <= cfg_data[sspt_pkg::ZONE_W-1:0];
				sspt_pkg::REG_START_OFFSET: offset_q <= cfg_data[sspt_pkg::POS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_tick_q <= '0;
			count_q     <= '0;
			speed_q     <= '0;
			pos_q       <= '0;
			hit_q       <= 1'b0;
			zero_q      <= 1'b0;
			m_tvalid    <= 1'b0;
			m_tdata     <= '0;
			m_tuser     <= '0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						hit_q  <= is_hit;
						zero_q <= 1'b0;
						if (is_hit) begin
							prev_tick_q <= ev_tick;
							count_q     <= count_q + 1'b1;
							if (diff == '0) begin
								zero_q  <= 1'b1;
								speed_q <= sspt_pkg::SPEED_SAT;
								state_q <= ST_MUL;
							end else begin
								state_q <= ST_DIV;
							end
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DIV: begin
					if (div_res.done) begin
						speed_q <= div_res.quotient;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					pos_q   <= offset_q + prod_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						m_tdata <= {count_q, speed_q, pos_q};
						m_tuser <= {zero_q, hit_q};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_q <= prod_full[sspt_pkg::POS_W-1:0];
		end
	end

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == ST_DIV))
		else $error("divider result outside the divide state");

	a_zero_has_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> m_tuser[0])
		else $error("zero interval flagged without a strobe");

	a_zero_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tdata[47:32] == sspt_pkg::SPEED_SAT))
		else $error("zero interval without saturated speed");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_hit) |=> (count_q == $past(count_q) + 1'b1))
		else $error("strobe count not advanced on a strobe");

endmodule

// File: dv/strobe_speed_position_tracker_chk.sv
`timescale 1ns / 100ps

module strobe_speed_position_tracker_chk (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [47:0]                    s_tdata,  // event_source, event_level, event_tick
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [79:0]                    m_tdata,  // position_now, speed_now, strobes_seen
	input  logic [1:0]                     m_tuser,  // strobe_hit, zero_interval
	input  logic                           cfg_we,
	input  logic [sspt_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [sspt_pkg::CFG_W-1:0]     cfg_data,
	output int                             fails,
	output int                             pending
);

	typedef struct packed {
		logic                         hit;
		logic                         zero;
		logic [sspt_pkg::POS_W-1:0]   position;
		logic [sspt_pkg::SPEED_W-1:0] speed;
		logic [sspt_pkg::COUNT_W-1:0] count;
	} report_t;

	logic [sspt_pkg::SRC_W-1:0]   sel_source;
	logic                         sel_level;
	logic [sspt_pkg::ZONE_W-1:0]  zone_len;
	logic [sspt_pkg::POS_W-1:0]   pos_offset;

	logic [sspt_pkg::TICK_W-1:0]  last_strobe_tick;
	logic [sspt_pkg::COUNT_W-1:0] strobe_total;
	logic [sspt_pkg::SPEED_W-1:0] speed_reg;
	logic [sspt_pkg::POS_W-1:0]   position_reg;

	report_t expected_reports[$];
	int      shown;

	function automatic report_t track_event(input logic [sspt_pkg::SRC_W-1:0] src,
			input logic lvl, input logic [sspt_pkg::TICK_W-1:0] tick);
		report_t                     r;
		logic [sspt_pkg::TICK_W-1:0] gap;
		r.hit  = 1'b0;
		r.zero = 1'b0;
		if (src == sel_source && lvl == sel_level) begin
			gap   = tick - last_strobe_tick;
			r.hit = 1'b1;
			if (gap == '0) begin
				speed_reg = '1;
				r.zero    = 1'b1;
			end else begin
				speed_reg = 16'({16'd0, zone_len} / gap);
			end
			last_strobe_tick = tick;
			strobe_total     = strobe_total + 32'd1;
			position_reg     = pos_offset + strobe_total * {16'd0, zone_len};
		end
		r.position = position_reg;
		r.speed    = speed_reg;
		r.count    = strobe_total;
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input report_t exp, input report_t act);
		fails++;
		if (shown < 10) begin
			shown++;
			$display("[%0t] %s: exp hit=%0b zero=%0b pos=%08h speed=%04h count=%08h", $realtime,
				what, exp.hit, exp.zero, exp.position, exp.speed, exp.count);
			$display("[%0t] %s: got hit=%0b zero=%0b pos=%08h speed=%04h count=%08h", $realtime,
				what, act.hit, act.zero, act.position, act.speed, act.count);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		report_t got;
		report_t exp;
		if (!arst_n) begin
			sel_source       = '0;
			sel_level        = 1'b1;
			zone_len         = sspt_pkg::ZONE_RESET;
			pos_offset       = '0;
			last_strobe_tick = '0;
			strobe_total     = '0;
			speed_reg        = '0;
			position_reg     = '0;
			expected_reports.delete();
			fails            = 0;
			shown            = 0;
			pending          = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.hit      = m_tuser[0];
				got.zero     = m_tuser[1];
				got.position = m_tdata[31:0];
				got.speed    = m_tdata[47:32];
				got.count    = m_tdata[79:48];
				if (expected_reports.size() == 0) begin
					flag_mismatch("unexpected report", '0, got);
				end else begin
					exp = expected_reports.pop_front();
					if (got.hit !== exp.hit || got.zero !== exp.zero ||
							got.position !== exp.position || got.speed !== exp.speed ||
							got.count !== exp.count)
						flag_mismatch("report mismatch", exp, got);
				end
			end
			if (cfg_we) begin
				case (cfg_addr)
					sspt_pkg::REG_SOURCE_ID:    sel_source = cfg_data[sspt_pkg::SRC_W-1:0];
					sspt_pkg::REG_MATCH_LEVEL:  sel_level  = cfg_data[0];
					sspt_pkg::REG_ZONE_LENGTH:  zone_len   = cfg_data[sspt_pkg::ZONE_W-1:0];
					sspt_pkg::REG_START_OFFSET: pos_offset = cfg_data[sspt_pkg::POS_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_reports.push_back(track_event(s_tdata[7:0], s_tdata[8], s_tdata[40:9]));
			pending = expected_reports.size();
		end
	end

endmodule

// File: dv/strobe_speed_position_tracker_tb.sv
`timescale 1ns / 100ps

module strobe_speed_position_tracker_tb;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [47:0]                    s_tdata;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [79:0]                    m_tdata;
	logic [1:0]                     m_tuser;
	logic                           cfg_we;
	logic [sspt_pkg::CFG_IDX_W-1:0] cfg_addr;
	logic [sspt_pkg::CFG_W-1:0]     cfg_data;

	int fails;
	int pending;

	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	bit hold_req     = 1'b0;

	// stimulus-side view of the settings, used to shape strobe sequences
	logic [sspt_pkg::SRC_W-1:0]  cur_src   = '0;
	logic                        cur_lvl   = 1'b1;
	logic [sspt_pkg::TICK_W-1:0] last_tick = '0;

	always #10 clk = ~clk;

	strobe_speed_position_tracker u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	strobe_speed_position_tracker_chk u_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.fails    (fails),
		.pending  (pending)
	);

	// result side: random stalls plus one long hold-off
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	task automatic send_event(input logic [sspt_pkg::SRC_W-1:0] src, input logic lvl,
			input logic [sspt_pkg::TICK_W-1:0] tick);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, tick, lvl, src};
		do @(posedge clk); while (!s_tready);
		if (src == cur_src && lvl == cur_lvl)
			last_tick = tick;
		@(negedge clk);
	endtask

	task automatic settle;
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_settings(input logic [sspt_pkg::SRC_W-1:0] src, input logic lvl,
			input logic [sspt_pkg::ZONE_W-1:0] zone, input logic [sspt_pkg::POS_W-1:0] offset);
		settle();
		cfg_we   <= 1'b1;
		cfg_addr <= sspt_pkg::REG_SOURCE_ID;
		cfg_data <= 32'(src);
		@(negedge clk);
		cfg_addr <= sspt_pkg::REG_MATCH_LEVEL;
		cfg_data <= 32'(lvl);
		@(negedge clk);
		cfg_addr <= sspt_pkg::REG_ZONE_LENGTH;
		cfg_data <= 32'(zone);
		@(negedge clk);
		cfg_addr <= sspt_pkg::REG_START_OFFSET;
		cfg_data <= offset;
		@(negedge clk);
		cfg_we   <= 1'b0;
		cur_src  = src;
		cur_lvl  = lvl;
		@(negedge clk);
	endtask

	task automatic random_settings;
		logic [sspt_pkg::SRC_W-1:0]  src;
		logic [sspt_pkg::ZONE_W-1:0] zone;
		logic [sspt_pkg::POS_W-1:0]  offset;
		case ($urandom_range(3))
			0:       src = '0;
			1:       src = '1;
			default: src = 8'($urandom_range(255));
		endcase
		case ($urandom_range(7))
			0:       zone = '0;
			1, 2:    zone = '1;
			3:       zone = 16'($urandom_range(16));
			default: zone = 16'($urandom_range(65535));
		endcase
		case ($urandom_range(3))
			0:       offset = '0;
			1:       offset = '1;
			default: offset = $urandom;
		endcase
		write_settings(src, 1'($urandom_range(1)), zone, offset);
	endtask

	// mostly well-formed strobe trains, some near misses and plain noise
	task automatic random_event;
		logic [sspt_pkg::SRC_W-1:0]  src;
		logic                        lvl;
		logic [sspt_pkg::TICK_W-1:0] tick;
		int                          pick;
		pick = $urandom_range(99);
		src  = cur_src;
		lvl  = cur_lvl;
		tick = $urandom;
		if (pick < 65) begin
			case ($urandom_range(4))
				0:       tick = last_tick + $urandom_range(3);
				1:       tick = last_tick + $urandom_range(1, 300);
				2:       tick = last_tick + $urandom_range(1, 70000);
				3:       tick = last_tick + $urandom_range(1, 20);
				default: tick = $urandom;
			endcase
		end else if (pick < 75) begin
			lvl = ~cur_lvl;
		end else if (pick < 85) begin
			src = cur_src ^ (8'd1 << $urandom_range(7));
		end else begin
			src = 8'($urandom_range(255));
			lvl = 1'($urandom_range(1));
		end
		send_event(src, lvl, tick);
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		cfg_we   = 1'b0;
		cfg_addr = sspt_pkg::REG_SOURCE_ID;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: first strobe at tick zero, misses, one-tick interval
		send_event(8'h00, 1'b1, 32'h0000_0000);
		send_event(8'h00, 1'b0, 32'h0000_0005);
		send_event(8'h01, 1'b1, 32'h0000_0006);
		send_event(8'h00, 1'b1, 32'h0000_0001);
		send_event(8'h00, 1'b1, 32'h0000_0004);

		// widest settings, tick wrap and zero interval
		write_settings(8'hFF, 1'b0, 16'hFFFF, 32'hFFFF_FFFF);
		send_event(8'hFF, 1'b0, 32'hFFFF_FFFF);
		send_event(8'hFF, 1'b0, 32'h0000_0000);
		send_event(8'hFF, 1'b0, 32'h0000_0000);
		send_event(8'hFF, 1'b1, 32'h0000_0003);
		send_event(8'h7F, 1'b0, 32'h0000_0003);
		send_event(8'hFF, 1'b0, 32'h0000_0002);
		send_event(8'hFF, 1'b0, 32'h0001_0001);
		send_event(8'hFF, 1'b0, 32'h8000_0000);

		// zero zone length
		write_settings(8'h5A, 1'b1, 16'h0000, 32'h1234_5678);
		send_event(8'h5A, 1'b1, 32'h0000_0064);
		send_event(8'h5A, 1'b1, 32'h0000_0064);
		send_event(8'h5A, 1'b1, 32'h0000_00C8);
		send_event(8'hA5, 1'b1, 32'h0000_0100);

		for (int blk = 0; blk < 6; blk++) begin
			random_settings();
			case (blk / 2)
				0: begin
					snd_idle_pct = 6;
					rcv_idle_pct = 77;
				end
				1: begin
					snd_idle_pct = 77;
					rcv_idle_pct = 6;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			if (blk == 4)
				hold_req = 1'b1;
			repeat (230) random_event();
		end

		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (fails == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/sspt_pkg.sv
hw/rtl/sspt_div.sv
hw/rtl/strobe_speed_position_tracker.sv
dv/strobe_speed_position_tracker_chk.sv
dv/strobe_speed_position_tracker_tb.sv
